[src/fvn_pkg.sv]
package fvn_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_PHASE       = 3'd0,
        CFG_SEED        = 3'd1,
        CFG_FREQUENCY   = 3'd2,
        CFG_OCTAVES     = 3'd3,
        CFG_RANGE_LOW   = 3'd4,
        CFG_OUTPUT_SPAN = 3'd5,
        CFG_GAIN        = 3'd6,
        CFG_BIAS        = 3'd7
    } t_cfg_idx;

    // Per-item flags that ride along with the shaping dividers.
    typedef struct packed {
        logic hi;
        logic lo;
        logic off;
    } t_shape_sb;

    localparam int TERM_W    = 56;
    localparam int OCT_LAT   = 7;
    localparam int BIAS_LAT  = 34;
    localparam int PIPE_LAT  = 2 + OCT_LAT + 2 + 3 + BIAS_LAT + 1 + BIAS_LAT + 3;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
    localparam logic signed [33:0] HI_Q30 = 34'sd1072668082;
    localparam logic signed [33:0] LO_Q30 = 34'sd10737;
    localparam logic signed [31:0] UNIFORM_Q30 = 32'sd1471026299;
    localparam logic signed [36:0] SEED_OFS_Q32 = 37'sd53549652247;

    localparam logic [31:0] HASH_SEED_MUL = 32'd137;
    localparam logic [31:0] HASH_MUL      = 32'd15731;
    localparam logic [31:0] HASH_ADD1     = 32'd789221;
    localparam logic [31:0] HASH_ADD2     = 32'd1376312589;

    localparam logic [16:0] SHAPE_ONE = 17'd65536;
    localparam logic [16:0] SHAPE_MID = 17'd32768;

endpackage

[src/fractal_value_noise_gain_bias.sv]
// One-dimensional fractal value noise with Schlick gain and bias shaping.
// Input channel: i_valid / o_stall with one time sample (signed Q16.16) per
// item. Output channel: o_valid / i_stall with one shaped value per item,
// signed Q16.16, saturated to 32 bits. An item is taken on a clock edge with
// valid high and stall low.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register
// per write. The user must change it only while no item is in flight; the
// block itself does not enforce this. A result reaches o_valid through 86
// register stages from the edge that accepts its item.
// Throughput is one item per cycle when not stalled: every octave has its own seven-stage
// hash and interpolation pipeline, and the two bias curves each run through
// a 34-stage unit whose divider resolves one quotient bit per stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises, so nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults: phase 0, seed 0, frequency 1.0, octave setting 4, range low 0,
// span 1.0, gain 0.5, bias 0.5.
module fractal_value_noise_gain_bias #(
    parameter int MAX_OCTAVES = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_time_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NOCT = MAX_OCTAVES - 1;
    localparam int NGRP = (NOCT + 3) / 4;
    localparam int TW   = fvn_pkg::TERM_W;

    // Configuration registers.
    logic [31:0] r_phase;
    logic [17:0] r_seed;
    logic [31:0] r_freq;
    logic [4:0]  r_oct;
    logic [31:0] r_rlow;
    logic [31:0] r_span;
    logic [16:0] r_gain;
    logic [16:0] r_bias;

    // Values derived from configuration, refreshed every cycle.
    logic [63:0] r_sofs;
    logic [31:0] r_sd137;
    logic [5:0]  r_octc;
    logic [16:0] r_g;
    logic [16:0] r_gcomp;
    logic [16:0] r_b;
    logic        r_casea;

    logic [fvn_pkg::PIPE_LAT-1:0] r_vld;
    logic en;

    logic signed [32:0]   r_tp;
    logic [63:0]          r_prod;
    logic signed [TW-1:0] term   [NOCT];
    logic signed [TW-1:0] term_m [NGRP*4];
    logic signed [TW-1:0] n_grp  [NGRP];
    logic signed [TW-1:0] r_grp  [NGRP];
    logic signed [TW-1:0] n_acc;
    logic signed [TW-1:0] r_acc;
    logic signed [63:0]   r_m;
    logic signed [33:0]   r_inner;
    logic [30:0]          r_x1;
    logic [16:0]          r_b1;
    fvn_pkg::t_shape_sb   r_sb1;
    logic [30:0]          r_x2;
    logic [16:0]          r_b2;
    fvn_pkg::t_shape_sb   r_sb2;
    logic [30:0]          r_gb;
    logic signed [63:0]   r_sp;
    logic [31:0]          r_out;

    logic [30:0]          q1;
    logic [30:0]          q2;
    fvn_pkg::t_shape_sb   sb1_o;
    fvn_pkg::t_shape_sb   sb2_o;

    logic signed [54:0]   sofs_full;
    logic [31:0]          seed32;
    logic signed [64:0]   prod_full;
    logic signed [67:0]   m_full;
    logic signed [34:0]   inner_sum;
    logic                 hi;
    logic                 lo;
    logic                 in_low;
    logic [31:0]          x1_dbl;
    logic [30:0]          y;
    logic                 y_low;
    logic [31:0]          y_dbl;
    logic [30:0]          gb_half;
    logic signed [34:0]   res_sum;
    logic [16:0]          g_cl;

    assign en      = ~r_vld[fvn_pkg::PIPE_LAT-1] | ~i_stall;
    assign o_stall = ~en;
    assign o_valid = r_vld[fvn_pkg::PIPE_LAT-1];
    assign o_result_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_seed  <= '0;
            r_freq  <= 32'd65536;
            r_oct   <= 5'd4;
            r_rlow  <= '0;
            r_span  <= 32'd65536;
            r_gain  <= fvn_pkg::SHAPE_MID;
            r_bias  <= fvn_pkg::SHAPE_MID;
        end else if (i_cfg_we) begin
            case (fvn_pkg::t_cfg_idx'(i_cfg_idx))
                fvn_pkg::CFG_PHASE:       r_phase <= i_cfg_data;
                fvn_pkg::CFG_SEED:        r_seed  <= i_cfg_data[17:0];
                fvn_pkg::CFG_FREQUENCY:   r_freq  <= i_cfg_data;
                fvn_pkg::CFG_OCTAVES:     r_oct   <= i_cfg_data[4:0];
                fvn_pkg::CFG_RANGE_LOW:   r_rlow  <= i_cfg_data;
                fvn_pkg::CFG_OUTPUT_SPAN: r_span  <= i_cfg_data;
                fvn_pkg::CFG_GAIN:        r_gain  <= i_cfg_data[16:0];
                fvn_pkg::CFG_BIAS:        r_bias  <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sofs_full = $signed(r_seed) * fvn_pkg::SEED_OFS_Q32;
        seed32    = {{14{r_seed[17]}}, r_seed};
        g_cl      = (r_gain > fvn_pkg::SHAPE_ONE) ? fvn_pkg::SHAPE_ONE : r_gain;
    end

    always_ff @(posedge i_clk) begin
        r_sofs  <= {{9{sofs_full[54]}}, sofs_full};
        r_sd137 <= seed32 * fvn_pkg::HASH_SEED_MUL;
        if (r_oct == 5'd0) begin
            r_octc <= 6'd1;
        end else if ({1'b0, r_oct} > 6'(MAX_OCTAVES)) begin
            r_octc <= 6'(MAX_OCTAVES);
        end else begin
            r_octc <= {1'b0, r_oct};
        end
        r_g     <= g_cl;
        r_gcomp <= fvn_pkg::SHAPE_ONE - g_cl;
        r_casea <= (g_cl < fvn_pkg::SHAPE_MID);
        r_b     <= (r_bias > fvn_pkg::SHAPE_ONE) ? fvn_pkg::SHAPE_ONE : r_bias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[fvn_pkg::PIPE_LAT-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < NOCT; k++) begin : g_oct
        fvn_octave #(
            .OCTAVE (k)
        ) u_oct (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_prod  (r_prod),
            .i_sofs  (r_sofs),
            .i_sd137 (r_sd137),
            .o_term  (term[k])
        );
    end

    always_comb begin
        prod_full = r_tp * $signed(r_freq);

        // Only octave_count minus one octaves contribute.
        for (int k = 0; k < NGRP * 4; k++) begin
            term_m[k] = '0;
        end
        for (int k = 0; k < NOCT; k++) begin
            if (r_octc > 6'(k + 1)) begin
                term_m[k] = term[k];
            end
        end
        for (int gi = 0; gi < NGRP; gi++) begin
            n_grp[gi] = term_m[4*gi] + term_m[4*gi+1] + term_m[4*gi+2] + term_m[4*gi+3];
        end
        n_acc = '0;
        for (int gi = 0; gi < NGRP; gi++) begin
            n_acc = n_acc + r_grp[gi];
        end

        m_full    = $signed(r_acc[TW-1:20]) * fvn_pkg::UNIFORM_Q30;
        inner_sum = $signed({r_m[63], r_m[63:30]}) + $signed({4'b0, fvn_pkg::ONE_Q30});

        // Order of the two curves follows the gain; values near the ends skip them.
        hi     = (r_inner > fvn_pkg::HI_Q30);
        lo     = (r_inner < fvn_pkg::LO_Q30);
        in_low = (r_inner < $signed({3'b0, fvn_pkg::HALF_Q30}));
        x1_dbl = {r_inner[30:0], 1'b0};

        if (r_casea) begin
            y = q1;
        end else if (sb1_o.off) begin
            y = {1'b0, q1[30:1]} + fvn_pkg::HALF_Q30;
        end else begin
            y = {1'b0, q1[30:1]};
        end
        y_low = (y < fvn_pkg::HALF_Q30);
        y_dbl = {y, 1'b0};

        if (sb2_o.off) begin
            gb_half = {1'b0, q2[30:1]} + fvn_pkg::HALF_Q30;
        end else begin
            gb_half = {1'b0, q2[30:1]};
        end

        res_sum = $signed({r_sp[63], r_sp[63:30]}) + $signed({{3{r_rlow[31]}}, r_rlow});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tp   <= $signed({i_time_value[31], i_time_value})
                    + $signed({r_phase[31], r_phase});
            r_prod <= prod_full[63:0];
            for (int gi = 0; gi < NGRP; gi++) begin
                r_grp[gi] <= n_grp[gi];
            end
            r_acc   <= n_acc;
            r_m     <= m_full[63:0];
            r_inner <= inner_sum[34:1];

            if (r_casea) begin
                r_x1 <= r_inner[30:0];
                r_b1 <= r_b;
            end else if (in_low) begin
                r_x1 <= x1_dbl[30:0];
                r_b1 <= r_g;
            end else begin
                r_x1 <= 31'(x1_dbl - {1'b0, fvn_pkg::ONE_Q30});
                r_b1 <= r_gcomp;
            end
            r_sb1.hi  <= hi;
            r_sb1.lo  <= lo;
            r_sb1.off <= ~in_low;

            if (!r_casea) begin
                r_x2 <= y;
                r_b2 <= r_b;
            end else if (y_low) begin
                r_x2 <= y_dbl[30:0];
                r_b2 <= r_g;
            end else begin
                r_x2 <= 31'(y_dbl - {1'b0, fvn_pkg::ONE_Q30});
                r_b2 <= r_gcomp;
            end
            r_sb2.hi  <= sb1_o.hi;
            r_sb2.lo  <= sb1_o.lo;
            r_sb2.off <= ~y_low;

            if (sb2_o.hi) begin
                r_gb <= fvn_pkg::ONE_Q30;
            end else if (sb2_o.lo) begin
                r_gb <= '0;
            end else if (r_casea) begin
                r_gb <= gb_half;
            end else begin
                r_gb <= q2;
            end

            r_sp <= $signed({1'b0, r_gb}) * $signed(r_span);

            if (res_sum > 35'sd2147483647) begin
                r_out <= 32'h7fff_ffff;
            end else if (res_sum < -35'sd2147483648) begin
                r_out <= 32'h8000_0000;
            end else begin
                r_out <= res_sum[31:0];
            end
        end
    end

    fvn_bias u_bias1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_x1),
        .i_b   (r_b1),
        .i_sb  (r_sb1),
        .o_q   (q1),
        .o_sb  (sb1_o)
    );

    fvn_bias u_bias2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_x2),
        .i_b   (r_b2),
        .i_sb  (r_sb2),
        .o_q   (q2),
        .o_sb  (sb2_o)
    );

endmodule

[src/fvn_octave.sv]
module fvn_octave #(
    parameter int OCTAVE = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [63:0]                         i_prod,
    input  logic [63:0]                         i_sofs,
    input  logic [31:0]                         i_sd137,
    output logic signed [fvn_pkg::TERM_W-1:0]   o_term
);

    logic [63:0]        r_v;
    logic [31:0]        r_n   [2];
    logic [29:0]        r_t1;
    logic [31:0]        r_nx3 [2];
    logic [31:0]        r_nn  [2];
    logic [29:0]        r_t2;
    logic [29:0]        r_tc3;
    logic [31:0]        r_nx4 [2];
    logic [31:0]        r_p   [2];
    logic [29:0]        r_t3;
    logic [33:0]        r_u;
    logic signed [31:0] r_h   [2];
    logic [30:0]        r_f;
    logic signed [63:0] r_d;
    logic signed [31:0] r_h0;
    logic signed [fvn_pkg::TERM_W-1:0] r_term;

    logic [31:0]        lat;
    logic [31:0]        nx    [2];
    logic [31:0]        q     [2];
    logic [59:0]        tt;
    logic [59:0]        t3p;
    logic [35:0]        u_pos;
    logic [35:0]        u_neg;
    logic [63:0]        fp;
    logic signed [32:0] diff;
    logic signed [64:0] dp;
    logic signed [34:0] lerp;
    logic signed [fvn_pkg::TERM_W-1:0] wide;

    always_comb begin
        // Truncation toward zero: a negative position with a fraction steps up by one.
        lat   = r_v[63:32] + {31'd0, r_v[63] & (|r_v[31:0])};
        tt    = r_t1 * r_t1;
        t3p   = r_t2 * r_tc3;
        u_pos = 36'd10737418240 + 36'd6 * {6'd0, r_t2};
        u_neg = 36'd15 * {6'd0, r_tc3};
        fp    = {34'd0, r_t3} * {30'd0, r_u};
        diff  = $signed({r_h[1][31], r_h[1]}) - $signed({r_h[0][31], r_h[0]});
        dp    = diff * $signed({1'b0, r_f});
        lerp  = $signed({{3{r_h0[31]}}, r_h0}) + $signed({r_d[63], r_d[63:30]});
        wide  = $signed({{(fvn_pkg::TERM_W - 35){lerp[34]}}, lerp}) <<< 20;
        for (int j = 0; j < 2; j++) begin
            nx[j] = (r_n[j] << 13) ^ r_n[j];
            q[j]  = r_p[j] * r_nx4[j] + fvn_pkg::HASH_ADD2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v     <= (i_prod << OCTAVE) + i_sofs;
            r_n[0]  <= lat + i_sd137;
            r_n[1]  <= lat + i_sd137 + 32'd1;
            r_t1    <= r_v[31:2];
            r_t2    <= tt[59:30];
            r_tc3   <= r_t1;
            r_t3    <= t3p[59:30];
            r_u     <= (u_pos >= u_neg) ? 34'(u_pos - u_neg) : 34'd0;
            r_f     <= fp[60:30];
            r_d     <= dp[63:0];
            r_h0    <= r_h[0];
            r_term  <= wide >>> (OCTAVE + 1);
            for (int j = 0; j < 2; j++) begin
                r_nx3[j] <= nx[j];
                r_nn[j]  <= nx[j] * nx[j];
                r_nx4[j] <= r_nx3[j];
                r_p[j]   <= r_nn[j] * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD1;
                r_h[j]   <= $signed({1'b0, fvn_pkg::ONE_Q30}) - $signed({1'b0, q[j][30:0]});
            end
        end
    end

    assign o_term = r_term;

endmodule

[src/fvn_bias.sv]
module fvn_bias (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [30:0]          i_x,
    input  logic [16:0]          i_b,
    input  fvn_pkg::t_shape_sb   i_sb,
    output logic [30:0]          o_q,
    output fvn_pkg::t_shape_sb   o_sb
);

    localparam int QW = 31;

    typedef struct packed {
        logic zero;
        logic den_le;
        logic ovf;
    } t_div_flags;

    logic [61:0]          r_num;
    logic signed [63:0]   r_pr;
    logic [30:0]          r_xa;
    fvn_pkg::t_shape_sb   r_sba;

    logic [31:0]          r_rem [QW+1];
    logic [30:0]          r_lo  [QW+1];
    logic [31:0]          r_den [QW+1];
    logic [30:0]          r_q   [QW+1];
    t_div_flags           r_fl  [QW+1];
    fvn_pkg::t_shape_sb   r_sb  [QW+1];

    logic [30:0]          r_res;
    fvn_pkg::t_shape_sb   r_sbo;

    logic [30:0]          b30;
    logic signed [32:0]   xm;
    logic signed [64:0]   pr;
    logic signed [34:0]   den;
    t_div_flags           fl;
    logic [32:0]          tr   [QW];
    logic                 ge   [QW];

    always_comb begin
        b30 = {i_b[16:0], 14'd0};
        xm  = $signed({1'b0, i_x, 1'b0}) - $signed({2'b0, fvn_pkg::ONE_Q30});
        pr  = $signed({1'b0, b30}) * xm;
        den = $signed({4'b0, fvn_pkg::ONE_Q30}) - $signed({4'b0, r_xa})
            + $signed({r_pr[63], r_pr[63:30]});
        fl.zero   = (r_num == 62'd0);
        fl.den_le = (den <= 35'sd0);
        // A quotient of 2^31 or more saturates anyway.
        fl.ovf    = ({1'b0, r_num[61:31]} >= den[31:0]);
        for (int j = 0; j < QW; j++) begin
            tr[j] = {r_rem[j], r_lo[j][30]};
            ge[j] = (tr[j] >= {1'b0, r_den[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num    <= {31'd0, b30} * {31'd0, i_x};
            r_pr     <= pr[63:0];
            r_xa     <= i_x;
            r_sba    <= i_sb;

            r_rem[0] <= {1'b0, r_num[61:31]};
            r_lo[0]  <= r_num[30:0];
            r_den[0] <= den[31:0];
            r_q[0]   <= '0;
            r_fl[0]  <= fl;
            r_sb[0]  <= r_sba;

            // Restoring division, one quotient bit per stage.
            for (int j = 0; j < QW; j++) begin
                r_rem[j+1] <= ge[j] ? 32'(tr[j] - {1'b0, r_den[j]}) : tr[j][31:0];
                r_lo[j+1]  <= {r_lo[j][29:0], 1'b0};
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][29:0], ge[j]};
                r_fl[j+1]  <= r_fl[j];
                r_sb[j+1]  <= r_sb[j];
            end

            if (r_fl[QW].zero) begin
                r_res <= '0;
            end else if (r_fl[QW].den_le || r_fl[QW].ovf) begin
                r_res <= fvn_pkg::ONE_Q30;
            end else if (r_q[QW] > fvn_pkg::ONE_Q30) begin
                r_res <= fvn_pkg::ONE_Q30;
            end else begin
                r_res <= r_q[QW];
            end
            r_sbo <= r_sb[QW];
        end
    end

    assign o_q  = r_res;
    assign o_sb = r_sbo;

endmodule

[tb/sv/fractal_value_noise_gain_bias_test.sv]
`timescale 1ns / 100ps

module fractal_value_noise_gain_bias_test;
    import fvn_pkg::*;

    localparam int MAX_OCT = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_time_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    fractal_value_noise_gain_bias #(.MAX_OCTAVES(MAX_OCT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_time_value(i_time_value), .o_valid(o_valid), .i_stall(i_stall),
        .o_result_value(o_result_value), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [31:0] cur_phase, cur_freq, cur_range_low, cur_span;
    logic [17:0] cur_seed;
    logic [4:0]  cur_octaves;
    logic [16:0] cur_gain, cur_bias;

    logic [31:0] expected_values[$];
    int mismatches;
    int results_seen;
    int items_sent;
    int idle_cycles;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint lattice_hash(logic [31:0] x, logic [31:0] sd);
        logic [31:0] n;
        logic [31:0] v;
        n = x + sd * 32'd137;
        n = (n << 13) ^ n;
        v = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
        return (longint'(1) << 30) - longint'({1'b0, v[30:0]});
    endfunction

    function automatic longint quintic_fade(longint t);
        longint t2, t3, u;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        u = 10 * (longint'(1) << 30) - 15 * t + 6 * t2;
        if (u < 0) u = 0;
        return (t3 * u) >> 30;
    endfunction

    function automatic longint bias_curve(longint x, longint b16);
        longint b30, num, den;
        longint q;
        b30 = b16 << 14;
        num = x * b30;
        den = ((longint'(1) << 30) - x) + floor_shift(b30 * (2 * x - (longint'(1) << 30)), 30);
        if (num <= 0) return 0;
        if (den <= 0) return longint'(1) << 30;
        q = num / den;
        return (q > (longint'(1) << 30)) ? (longint'(1) << 30) : q;
    endfunction

    function automatic longint schlick_gain(longint g16, longint x);
        if (x < (longint'(1) << 29)) return bias_curve(2 * x, g16) / 2;
        return bias_curve(2 * x - (longint'(1) << 30), 65536 - g16) / 2 + (longint'(1) << 29);
    endfunction

    function automatic logic [31:0] shaped_noise(logic [31:0] tv);
        longint t, sd, acc, s30, inner, gb, res, lerp, h0, h1, f, g, b;
        logic [63:0] prod, sofs, v;
        logic [31:0] lat, frac;
        int oct;
        t = longint'($signed(tv)) + longint'($signed(cur_phase));
        prod = t * longint'($signed(cur_freq));
        sd = longint'($signed(cur_seed));
        sofs = sd * 64'd53549652247;
        oct = cur_octaves;
        g = (cur_gain > 17'd65536) ? 65536 : cur_gain;
        b = (cur_bias > 17'd65536) ? 65536 : cur_bias;
        if (oct < 1) oct = 1;
        if (oct > MAX_OCT) oct = MAX_OCT;
        acc = 0;
        for (int k = 0; k + 1 < oct; k++) begin
            v = (prod << k) + sofs;
            lat = v[63:32];
            frac = v[31:0];
            // Truncation toward zero lifts negative non-integer positions.
            if (v[63] && frac != 0) lat = lat + 1;
            h0 = lattice_hash(lat, sd[31:0]);
            h1 = lattice_hash(lat + 1, sd[31:0]);
            f = quintic_fade(longint'(frac >> 2));
            lerp = h0 + floor_shift((h1 - h0) * f, 30);
            acc += floor_shift(lerp * 1048576, k + 1);
        end
        s30 = floor_shift(acc, 20);
        inner = floor_shift(floor_shift(s30 * 1471026299, 30) + (longint'(1) << 30), 1);
        if (inner > 1072668082) gb = longint'(1) << 30;
        else if (inner < 10737) gb = 0;
        else if (g < 32768) gb = schlick_gain(g, bias_curve(inner, b));
        else gb = bias_curve(schlick_gain(g, inner), b);
        res = floor_shift(gb * longint'($signed(cur_span)), 30) + longint'($signed(cur_range_low));
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Result checker and receiver stall generation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_values.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %h", o_result_value);
                end else begin
                    logic [31:0] want;
                    want = expected_values.pop_front();
                    if (want !== o_result_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h, got %h", want, o_result_value);
                    end
                end
            end
            if (results_seen % 300 < 80) i_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 3) i_stall <= 1'b1;
            else if ($urandom_range(0, 99) < 40) i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic release_input();
        i_valid <= 1'b0;
        i_time_value <= $urandom;
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 40) n = 0;
        // With no gap the next item follows directly, so valid stays high.
        if (n > 0) release_input();
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] tv);
        i_valid <= 1'b1;
        i_time_value <= tv;
        expected_values = {expected_values, shaped_noise(tv)};
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic drain();
        release_input();
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE:       cur_phase = data;
            CFG_SEED:        cur_seed = data[17:0];
            CFG_FREQUENCY:   cur_freq = data;
            CFG_OCTAVES:     cur_octaves = data[4:0];
            CFG_RANGE_LOW:   cur_range_low = data;
            CFG_OUTPUT_SPAN: cur_span = data;
            CFG_GAIN:        cur_gain = data[16:0];
            CFG_BIAS:        cur_bias = data[16:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
        endcase
    endfunction

    task automatic test_defaults();
        logic [31:0] edges[8] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                  32'h0001_0000, 32'hffff_8000, 32'h0000_8000, 32'h5555_aaaa};
        foreach (edges[i]) send_sample(edges[i]);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_PHASE, 32'h7fff_ffff);
        write_reg(CFG_SEED, 32'(-100000));
        write_reg(CFG_FREQUENCY, 32'h8000_0000);
        write_reg(CFG_OCTAVES, 32'd20);
        write_reg(CFG_RANGE_LOW, 32'h7fff_0000);
        write_reg(CFG_OUTPUT_SPAN, 32'h7fff_ffff);
        write_reg(CFG_GAIN, 32'd65536);
        write_reg(CFG_BIAS, 32'd0);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        drain();
        // Octave settings of zero, one and 31, oversized gain and bias, zero gain.
        write_reg(CFG_OCTAVES, 32'd0);
        write_reg(CFG_GAIN, 32'h1_ffff);
        write_reg(CFG_BIAS, 32'h1_ffff);
        write_reg(CFG_SEED, 32'd100000);
        send_sample(32'h1234_5678);
        drain();
        write_reg(CFG_OCTAVES, 32'd1);
        send_sample(32'h1234_5678);
        drain();
        write_reg(CFG_OCTAVES, 32'd31);
        write_reg(CFG_GAIN, 32'd0);
        write_reg(CFG_BIAS, 32'd65536);
        write_reg(CFG_RANGE_LOW, 32'h8000_0000);
        write_reg(CFG_OUTPUT_SPAN, 32'h8000_0000);
        write_reg(CFG_PHASE, 32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'hffff_0001);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase_no = 0; phase_no < 12; phase_no++) begin
            write_reg(CFG_PHASE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
            write_reg(CFG_SEED, 32'($urandom_range(0, 200000)) - 32'd100000);
            write_reg(CFG_FREQUENCY, $urandom_range(0, 2) == 0 ? $urandom
                      : 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000);
            write_reg(CFG_OCTAVES, $urandom_range(0, 31));
            write_reg(CFG_RANGE_LOW, $urandom);
            write_reg(CFG_OUTPUT_SPAN, $urandom_range(0, 1) ? $urandom
                      : 32'($urandom_range(0, 1 << 18)) - 32'h0002_0000);
            write_reg(CFG_GAIN, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                      : $urandom_range(0, 65536));
            write_reg(CFG_BIAS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                      : $urandom_range(0, 65536));
            for (int n = 0; n < 105; n++) begin
                send_sample(random_time());
                random_gap();
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_time_value = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PHASE;
        i_cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        cur_phase = 32'd0;
        cur_seed = 18'd0;
        cur_freq = 32'd65536;
        cur_octaves = 5'd4;
        cur_range_low = 32'd0;
        cur_span = 32'd65536;
        cur_gain = 17'd32768;
        cur_bias = 17'd32768;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_register_extremes();
        test_random_settings();
        $display("Sent %0d samples and checked %0d results over default, extreme and random",
                 items_sent, results_seen);
        $display("register settings, with random stalls on both sides.");
        if (mismatches == 0 && expected_values.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
